// ----- rtl/pinned_lru_page_buffer_manager_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef PINNED_LRU_PAGE_BUFFER_MANAGER_MACROS_SVH
`define PINNED_LRU_PAGE_BUFFER_MANAGER_MACROS_SVH
`ifndef SYNTH
`define PLBM_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");
`define PLBM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define PLBM_ASSERT_IMPL(label, clk, rst_n, a, b)
`define PLBM_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- rtl/plbm_pkg.sv -----
`default_nettype none
package plbm_pkg;
    localparam int NUM_FRAMES = 16;
    localparam int PIN_BITS   = 8;
    localparam int FILE_BITS  = 8;
    localparam int IDX_W      = $clog2(NUM_FRAMES);
    localparam int LINK_W     = $clog2(NUM_FRAMES + 1);

    typedef logic [LINK_W-1:0] t_link;
    localparam t_link NIL = t_link'(NUM_FRAMES);
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    localparam logic [2:0] OP_GET        = 3'd0;
    localparam logic [2:0] OP_ALLOCATE   = 3'd1;
    localparam logic [2:0] OP_MARK_DIRTY = 3'd2;
    localparam logic [2:0] OP_UNPIN      = 3'd3;
    localparam logic [2:0] OP_FORCE_PAGE = 3'd4;
    localparam logic [2:0] OP_FORCE_FILE = 3'd5;
    localparam logic [2:0] OP_FLUSH_FILE = 3'd6;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_PINNED   = 3'd1;
    localparam logic [2:0] ST_NOT_IN   = 3'd2;
    localparam logic [2:0] ST_UNPINNED = 3'd3;
    localparam logic [2:0] ST_NO_FREE  = 3'd4;
    localparam logic [2:0] ST_ALREADY  = 3'd5;

    localparam logic [2:0] ATTR_NONE  = 3'd0;
    localparam logic [2:0] ATTR_LOAD  = 3'd1;
    localparam logic [2:0] ATTR_DIRTY = 3'd2;
    localparam logic [2:0] ATTR_CLEAN = 3'd3;
    localparam logic [2:0] ATTR_INC   = 3'd4;
    localparam logic [2:0] ATTR_DEC   = 3'd5;
    localparam logic [2:0] ATTR_FREE  = 3'd6;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  file_id;
        logic [31:0] page_number;
        logic        allow_multiple_pins;
    } t_request;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  frame;
        logic        fetch_needed;
        logic        writeback;
        logic [7:0]  wb_file;
        logic [31:0] wb_page;
        logic [3:0]  wb_frame;
        logic        last;
    } t_result;

    typedef struct packed {
        logic        next_we;
        t_link       next_idx;
        t_link       next_val;
        logic        prev_we;
        t_link       prev_idx;
        t_link       prev_val;
        logic [2:0]  attr_op;
        t_link       attr_idx;
    } t_cell_cmd;

    typedef struct packed {
        logic                 in_use;
        logic                 dirty;
        logic [PIN_BITS-1:0]  pins;
        t_link                next;
        t_link                prev;
        logic [FILE_BITS-1:0] file;
        logic [31:0]          page;
    } t_cell_view;
endpackage
`default_nettype wire

// ----- rtl/plbm_cell.sv -----
`default_nettype none
module plbm_cell (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [plbm_pkg::IDX_W-1:0]     i_index,
    input  wire plbm_pkg::t_cell_cmd            i_cmd,
    input  wire logic [plbm_pkg::FILE_BITS-1:0] i_key_file,
    input  wire logic [31:0]                    i_key_page,
    input  wire logic                           i_hit_in,
    input  wire plbm_pkg::t_link                i_hit_idx_in,
    output logic                                o_hit_out,
    output plbm_pkg::t_link                     o_hit_idx_out,
    output plbm_pkg::t_cell_view                o_view
);
    logic                           r_in_use;
    logic                           r_dirty;
    logic [plbm_pkg::PIN_BITS-1:0]  r_pins;
    plbm_pkg::t_link                r_next;
    plbm_pkg::t_link                r_prev;
    logic [plbm_pkg::FILE_BITS-1:0] r_file;
    logic [31:0]                    r_page;
    plbm_pkg::t_link                my_link;
    logic                           match;
    logic                           attr_sel;

    assign my_link  = plbm_pkg::t_link'(i_index);
    assign match    = r_in_use && (r_file == i_key_file) && (r_page == i_key_page);
    assign attr_sel = (i_cmd.attr_idx == my_link);

    assign o_hit_out     = i_hit_in || match;
    assign o_hit_idx_out = i_hit_in ? i_hit_idx_in : (match ? my_link : plbm_pkg::NIL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= 1'b0;
            r_dirty  <= 1'b0;
            r_pins   <= '0;
            r_next   <= my_link + plbm_pkg::t_link'(1);
            r_prev   <= (i_index == '0) ? plbm_pkg::NIL : my_link - plbm_pkg::t_link'(1);
        end else begin
            if (i_cmd.next_we && i_cmd.next_idx == my_link) begin
                r_next <= i_cmd.next_val;
            end
            if (i_cmd.prev_we && i_cmd.prev_idx == my_link) begin
                r_prev <= i_cmd.prev_val;
            end
            if (attr_sel) begin
                case (i_cmd.attr_op)
                    plbm_pkg::ATTR_LOAD: begin
                        r_in_use <= 1'b1;
                        r_dirty  <= 1'b0;
                        r_pins   <= plbm_pkg::PIN_BITS'(1);
                    end
                    plbm_pkg::ATTR_DIRTY: r_dirty  <= 1'b1;
                    plbm_pkg::ATTR_CLEAN: r_dirty  <= 1'b0;
                    plbm_pkg::ATTR_INC:   r_pins   <= r_pins + plbm_pkg::PIN_BITS'(1);
                    plbm_pkg::ATTR_DEC:   r_pins   <= r_pins - plbm_pkg::PIN_BITS'(1);
                    plbm_pkg::ATTR_FREE:  r_in_use <= 1'b0;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (attr_sel && i_cmd.attr_op == plbm_pkg::ATTR_LOAD) begin
            r_file <= i_key_file;
            r_page <= i_key_page;
        end
    end

    assign o_view.in_use = r_in_use;
    assign o_view.dirty  = r_dirty;
    assign o_view.pins   = r_pins;
    assign o_view.next   = r_next;
    assign o_view.prev   = r_prev;
    assign o_view.file   = r_file;
    assign o_view.page   = r_page;
endmodule
`default_nettype wire

// ----- rtl/pinned_lru_page_buffer_manager.sv -----
// Requests that keep the list order go straight to the status word; a pinning get hit, a
// mark dirty or an unpin that reaches zero first moves the frame to the head of the list.
// A get or allocate miss takes a frame from the free list, or scans from the tail past
// pinned frames for a victim, written back first when dirty. File walks visit each listed frame.
// One request at a time: the next word is accepted once the status word is loaded into the
// output register. Synchronous active-low reset empties the pool and frees every frame.
`default_nettype none
`include "pinned_lru_page_buffer_manager_macros.svh"
module pinned_lru_page_buffer_manager (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire plbm_pkg::t_request i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output plbm_pkg::t_result       o_out_data
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FIND = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_SCAN = 4'd3;
    localparam logic [3:0] S_WALK = 4'd4;
    localparam logic [3:0] S_WB   = 4'd5;
    localparam logic [3:0] S_U1   = 4'd6;
    localparam logic [3:0] S_U2   = 4'd7;
    localparam logic [3:0] S_L1   = 4'd8;
    localparam logic [3:0] S_L2   = 4'd9;
    localparam logic [3:0] S_FREE = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    localparam plbm_pkg::t_link N_LINK = plbm_pkg::NIL;

    logic [3:0]                     r_state, n_state;
    logic [2:0]                     r_op, n_op;
    logic [plbm_pkg::FILE_BITS-1:0] r_file, n_file;
    logic [31:0]                    r_page, n_page;
    logic                           r_multi, n_multi;
    logic                           r_hit, n_hit;
    logic                           r_take, n_take;
    plbm_pkg::t_link                r_s, n_s;
    plbm_pkg::t_link                r_nx, n_nx;
    plbm_pkg::t_link                r_steps, n_steps;
    plbm_pkg::t_link                r_head, n_head;
    plbm_pkg::t_link                r_tail, n_tail;
    plbm_pkg::t_link                r_free, n_free;
    logic [2:0]                     r_status, n_status;
    plbm_pkg::t_link                r_frame, n_frame;
    logic                           r_fetch, n_fetch;
    logic                           r_out_valid, n_out_valid;
    plbm_pkg::t_result              r_out, n_out;

    plbm_pkg::t_cell_cmd  cmd;
    plbm_pkg::t_cell_view views [plbm_pkg::NUM_FRAMES];
    logic                 hit_chain [plbm_pkg::NUM_FRAMES+1];
    plbm_pkg::t_link      idx_chain [plbm_pkg::NUM_FRAMES+1];
    plbm_pkg::t_cell_view v;
    logic                 s_ok;
    logic                 emit_ok;
    logic                 file_match;
    logic                 fin_fire;
    logic                 idle_done;

    assign hit_chain[0] = 1'b0;
    assign idx_chain[0] = N_LINK;

    for (genvar g = 0; g < plbm_pkg::NUM_FRAMES; g++) begin : g_cell
        plbm_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_index       (plbm_pkg::IDX_W'(g)),
            .i_cmd         (cmd),
            .i_key_file    (r_file),
            .i_key_page    (r_page),
            .i_hit_in      (hit_chain[g]),
            .i_hit_idx_in  (idx_chain[g]),
            .o_hit_out     (hit_chain[g+1]),
            .o_hit_idx_out (idx_chain[g+1]),
            .o_view        (views[g])
        );
    end

    assign s_ok       = (r_s < N_LINK);
    assign v          = views[r_s[plbm_pkg::IDX_W-1:0]];
    assign emit_ok    = !r_out_valid || i_out_ready;
    assign file_match = v.in_use && (v.file == r_file);
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign fin_fire    = (r_state == S_FIN) && emit_ok;
    assign idle_done   = (r_state == S_IDLE) && r_out_valid && r_out.last;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_file      = r_file;
        n_page      = r_page;
        n_multi     = r_multi;
        n_hit       = r_hit;
        n_take      = r_take;
        n_s         = r_s;
        n_nx        = r_nx;
        n_steps     = r_steps;
        n_head      = r_head;
        n_tail      = r_tail;
        n_free      = r_free;
        n_status    = r_status;
        n_frame     = r_frame;
        n_fetch     = r_fetch;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        cmd         = '0;
        cmd.attr_op = plbm_pkg::ATTR_NONE;
        cmd.attr_idx = r_s;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in_data.operation;
                    n_file   = i_in_data.file_id[plbm_pkg::FILE_BITS-1:0];
                    n_page   = i_in_data.page_number;
                    n_multi  = i_in_data.allow_multiple_pins;
                    n_status = plbm_pkg::ST_OK;
                    n_frame  = '0;
                    n_fetch  = 1'b0;
                    n_take   = 1'b0;
                    n_s      = r_head;
                    n_steps  = '0;
                    if (i_in_data.operation == plbm_pkg::OP_FORCE_FILE ||
                        i_in_data.operation == plbm_pkg::OP_FLUSH_FILE) begin
                        n_state = S_WALK;
                    end else if (i_in_data.operation > plbm_pkg::OP_FLUSH_FILE) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            S_FIND: begin
                n_hit = hit_chain[plbm_pkg::NUM_FRAMES];
                if (hit_chain[plbm_pkg::NUM_FRAMES]) begin
                    n_s     = idx_chain[plbm_pkg::NUM_FRAMES];
                    n_state = S_DEC;
                end else if (r_op == plbm_pkg::OP_GET || r_op == plbm_pkg::OP_ALLOCATE) begin
                    n_take  = 1'b1;
                    n_steps = '0;
                    if (r_free < N_LINK) begin
                        n_s     = r_free;
                        n_state = S_DEC;
                    end else begin
                        n_s     = r_tail;
                        n_state = S_SCAN;
                    end
                end else begin
                    n_status = plbm_pkg::ST_NOT_IN;
                    n_state  = S_FIN;
                end
            end
            S_DEC: begin
                if (!r_hit) begin
                    n_free  = v.next;
                    n_state = S_U2;
                end else begin
                    case (r_op)
                        plbm_pkg::OP_GET: begin
                            if ((!r_multi && v.pins != '0) || v.pins == plbm_pkg::PIN_MAX) begin
                                n_status = plbm_pkg::ST_PINNED;
                                n_state  = S_FIN;
                            end else begin
                                cmd.attr_op = plbm_pkg::ATTR_INC;
                                n_frame     = r_s;
                                n_state     = S_U1;
                            end
                        end
                        plbm_pkg::OP_ALLOCATE: begin
                            n_status = plbm_pkg::ST_ALREADY;
                            n_state  = S_FIN;
                        end
                        plbm_pkg::OP_MARK_DIRTY: begin
                            if (v.pins == '0) begin
                                n_status = plbm_pkg::ST_UNPINNED;
                                n_state  = S_FIN;
                            end else begin
                                cmd.attr_op = plbm_pkg::ATTR_DIRTY;
                                n_frame     = r_s;
                                n_state     = S_U1;
                            end
                        end
                        plbm_pkg::OP_UNPIN: begin
                            if (v.pins == '0) begin
                                n_status = plbm_pkg::ST_UNPINNED;
                                n_state  = S_FIN;
                            end else begin
                                cmd.attr_op = plbm_pkg::ATTR_DEC;
                                n_frame     = r_s;
                                n_state = (v.pins == plbm_pkg::PIN_BITS'(1)) ? S_U1 : S_FIN;
                            end
                        end
                        plbm_pkg::OP_FORCE_PAGE: begin
                            if (v.pins != '0) begin
                                n_status = plbm_pkg::ST_PINNED;
                                n_state  = S_FIN;
                            end else begin
                                n_frame = r_s;
                                n_state = v.dirty ? S_WB : S_FIN;
                            end
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN: begin
                if (s_ok && r_steps < N_LINK && v.pins != '0) begin
                    n_s     = v.prev;
                    n_steps = r_steps + plbm_pkg::t_link'(1);
                end else if (!s_ok || v.pins != '0) begin
                    n_status = plbm_pkg::ST_NO_FREE;
                    n_state  = S_FIN;
                end else begin
                    n_state = v.dirty ? S_WB : S_U1;
                end
            end
            S_WALK: begin
                if (s_ok && r_steps < N_LINK) begin
                    if (file_match && r_op == plbm_pkg::OP_FORCE_FILE) begin
                        if (v.pins != '0) begin
                            n_status = plbm_pkg::ST_PINNED;
                            n_state  = S_FIN;
                        end else if (v.dirty) begin
                            n_state = S_WB;
                        end else begin
                            n_s     = v.next;
                            n_steps = r_steps + plbm_pkg::t_link'(1);
                        end
                    end else if (file_match) begin
                        if (v.pins != '0) begin
                            n_status = plbm_pkg::ST_PINNED;
                            n_s      = v.next;
                            n_steps  = r_steps + plbm_pkg::t_link'(1);
                        end else begin
                            n_nx    = v.next;
                            n_state = v.dirty ? S_WB : S_U1;
                        end
                    end else begin
                        n_s     = v.next;
                        n_steps = r_steps + plbm_pkg::t_link'(1);
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WB: begin
                if (emit_ok) begin
                    n_out_valid      = 1'b1;
                    n_out            = '0;
                    n_out.status     = plbm_pkg::ST_OK;
                    n_out.writeback  = 1'b1;
                    n_out.wb_file    = 8'(v.file);
                    n_out.wb_page    = v.page;
                    n_out.wb_frame   = 4'(r_s);
                    cmd.attr_op      = plbm_pkg::ATTR_CLEAN;
                    case (r_op)
                        plbm_pkg::OP_FORCE_PAGE: n_state = S_FIN;
                        plbm_pkg::OP_FORCE_FILE: begin
                            n_s     = v.next;
                            n_steps = r_steps + plbm_pkg::t_link'(1);
                            n_state = S_WALK;
                        end
                        default: n_state = S_U1;
                    endcase
                end
            end
            S_U1: begin
                if (r_head == r_s) begin
                    n_head = v.next;
                end
                if (r_tail == r_s) begin
                    n_tail = v.prev;
                end
                cmd.prev_we  = (v.next < N_LINK);
                cmd.prev_idx = v.next;
                cmd.prev_val = v.prev;
                cmd.next_we  = (v.prev < N_LINK);
                cmd.next_idx = v.prev;
                cmd.next_val = v.next;
                n_state      = S_U2;
            end
            S_U2: begin
                cmd.next_we  = 1'b1;
                cmd.next_idx = r_s;
                cmd.next_val = N_LINK;
                cmd.prev_we  = 1'b1;
                cmd.prev_idx = r_s;
                cmd.prev_val = N_LINK;
                n_state = (r_op == plbm_pkg::OP_FLUSH_FILE) ? S_FREE : S_L1;
            end
            S_L1: begin
                cmd.next_we  = 1'b1;
                cmd.next_idx = r_s;
                cmd.next_val = r_head;
                cmd.prev_we  = 1'b1;
                cmd.prev_idx = r_s;
                cmd.prev_val = N_LINK;
                n_state      = S_L2;
            end
            S_L2: begin
                cmd.prev_we  = (r_head < N_LINK);
                cmd.prev_idx = r_head;
                cmd.prev_val = r_s;
                n_head       = r_s;
                if (r_tail >= N_LINK) begin
                    n_tail = r_s;
                end
                if (r_take) begin
                    cmd.attr_op = plbm_pkg::ATTR_LOAD;
                    n_frame     = r_s;
                    n_fetch     = (r_op == plbm_pkg::OP_GET);
                end
                n_state = S_FIN;
            end
            S_FREE: begin
                cmd.attr_op  = plbm_pkg::ATTR_FREE;
                cmd.next_we  = 1'b1;
                cmd.next_idx = r_s;
                cmd.next_val = r_free;
                n_free       = r_s;
                n_s          = r_nx;
                n_steps      = r_steps + plbm_pkg::t_link'(1);
                n_state      = S_WALK;
            end
            S_FIN: begin
                if (emit_ok) begin
                    n_out_valid        = 1'b1;
                    n_out              = '0;
                    n_out.status       = r_status;
                    n_out.frame        = 4'(r_frame);
                    n_out.fetch_needed = r_fetch;
                    n_out.last         = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= N_LINK;
            r_tail      <= N_LINK;
            r_free      <= '0;
            r_out_valid <= 1'b0;
            r_steps     <= '0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
            r_steps     <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_file   <= n_file;
        r_page   <= n_page;
        r_multi  <= n_multi;
        r_hit    <= n_hit;
        r_take   <= n_take;
        r_s      <= n_s;
        r_nx     <= n_nx;
        r_status <= n_status;
        r_frame  <= n_frame;
        r_fetch  <= n_fetch;
        r_out    <= n_out;
    end

    `PLBM_ASSERT_IMPL(a_list_ends, i_clk, i_rst_n, 1'b1, ((r_head >= N_LINK) == (r_tail >= N_LINK)))
    `PLBM_ASSERT_IMPL(a_steps_bound, i_clk, i_rst_n, 1'b1, (r_steps <= N_LINK))
    `PLBM_ASSERT_NEXT(a_fin_idle, i_clk, i_rst_n, fin_fire, idle_done)
endmodule
`default_nettype wire
